>>> src/awk_pkg.sv
`default_nettype none
package awk_pkg;

    localparam int CW    = 33;
    localparam int VW    = 60;
    localparam int DW    = 57;
    localparam int PW    = 92;
    localparam int QW    = 32;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 24;

    localparam logic [CFG_IDX_W-1:0] REG_WHEELBASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK     = 1'b1;

    localparam logic [CFG_W-1:0] WHEELBASE_RST = 24'd32768;
    localparam logic [CFG_W-1:0] TRACK_RST     = 24'd22282;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [CW-1:0] HALF_PI     = 33'sd1686629713;

    localparam logic signed [14:0] PHI_MAX = 15'sd12867;
    localparam logic signed [14:0] PHI_MIN = -15'sd12867;

    localparam logic signed [33:0] ANGLE_MAX = 34'sd25736;
    localparam logic signed [33:0] ANGLE_MIN = -34'sd25736;
    localparam logic signed [33:0] ROUND_HALF = 34'sd65536;

    typedef logic signed [CW-1:0] rot_t;
    typedef logic signed [VW-1:0] vec_t;
    typedef logic signed [15:0]   angle_t;
    typedef logic signed [31:0]   speed_t;

    function automatic logic [30:0] atan_q30(input logic [4:0] idx);
        logic [30:0] r;
        case (idx)
            5'd0:    r = 31'd843314856;
            5'd1:    r = 31'd497837829;
            5'd2:    r = 31'd263043836;
            5'd3:    r = 31'd133525158;
            5'd4:    r = 31'd67021686;
            5'd5:    r = 31'd33543515;
            5'd6:    r = 31'd16775850;
            5'd7:    r = 31'd8388437;
            5'd8:    r = 31'd4194282;
            5'd9:    r = 31'd2097149;
            5'd10:   r = 31'd1048575;
            5'd11:   r = 31'd524287;
            5'd12:   r = 31'd262143;
            5'd13:   r = 31'd131071;
            5'd14:   r = 31'd65535;
            5'd15:   r = 31'd32767;
            5'd16:   r = 31'd16383;
            5'd17:   r = 31'd8191;
            5'd18:   r = 31'd4095;
            5'd19:   r = 31'd2047;
            5'd20:   r = 31'd1023;
            5'd21:   r = 31'd511;
            5'd22:   r = 31'd255;
            5'd23:   r = 31'd127;
            default: r = 31'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/awk_if.sv
`default_nettype none
interface awk_cmd_if import awk_pkg::*;;
    logic              valid;
    logic              ready;
    logic signed [14:0] steer_angle;
    speed_t            linear_speed;

    modport source (output valid, output steer_angle, output linear_speed, input ready);
    modport sink   (input valid, input steer_angle, input linear_speed, output ready);
endinterface

interface awk_res_if import awk_pkg::*;;
    logic   valid;
    logic   ready;
    angle_t front_left_angle;
    angle_t front_right_angle;
    speed_t rear_left_speed;
    speed_t rear_right_speed;
    logic   speed_saturated;

    modport source (output valid, output front_left_angle, output front_right_angle,
                    output rear_left_speed, output rear_right_speed,
                    output speed_saturated, input ready);
    modport sink   (input valid, input front_left_angle, input front_right_angle,
                    input rear_left_speed, input rear_right_speed,
                    input speed_saturated, output ready);
endinterface
`default_nettype wire

>>> src/awk_vec.sv
`default_nettype none
module awk_vec import awk_pkg::*; #(
    parameter int STEPS = 16
) (
    input  wire logic clk,
    input  wire logic en,
    input  wire vec_t x,
    input  wire vec_t y,
    output angle_t    angle
);

    vec_t vx_reg [0:STEPS];
    vec_t vy_reg [0:STEPS];
    rot_t vz_reg [0:STEPS];
    logic zf_reg [0:STEPS];
    angle_t angle_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zf_reg[0] <= (x == '0) && (y == '0);
            if (x[VW-1])
            begin
                if (!y[VW-1])
                begin
                    vx_reg[0] <= y;
                    vy_reg[0] <= -x;
                    vz_reg[0] <= HALF_PI;
                end
                else
                begin
                    vx_reg[0] <= -y;
                    vy_reg[0] <= x;
                    vz_reg[0] <= -HALF_PI;
                end
            end
            else
            begin
                vx_reg[0] <= x;
                vy_reg[0] <= y;
                vz_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        vec_t sx;
        vec_t sy;
        rot_t at;
        assign sx = vx_reg[i] >>> i;
        assign sy = vy_reg[i] >>> i;
        assign at = rot_t'(atan_q30(5'(i)));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zf_reg[i+1] <= zf_reg[i];
                if (!vy_reg[i][VW-1])
                begin
                    vx_reg[i+1] <= vx_reg[i] + sy;
                    vy_reg[i+1] <= vy_reg[i] - sx;
                    vz_reg[i+1] <= vz_reg[i] + at;
                end
                else
                begin
                    vx_reg[i+1] <= vx_reg[i] - sy;
                    vy_reg[i+1] <= vy_reg[i] + sx;
                    vz_reg[i+1] <= vz_reg[i] - at;
                end
            end
        end
    end

    logic signed [33:0] zsum;
    logic signed [33:0] zq;
    angle_t             a_next;

    always_comb
    begin
        zsum = {vz_reg[STEPS][CW-1], vz_reg[STEPS]} + ROUND_HALF;
        zq   = zsum >>> 17;
        if (zf_reg[STEPS])
            a_next = '0;
        else if (zq > ANGLE_MAX)
            a_next = ANGLE_MAX[15:0];
        else if (zq < ANGLE_MIN)
            a_next = ANGLE_MIN[15:0];
        else
            a_next = zq[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= a_next;
    end

    assign angle = angle_reg;

endmodule
`default_nettype wire

>>> src/awk_div.sv
`default_nettype none
module awk_div import awk_pkg::*; (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire speed_t        v,
    input  wire vec_t          num,
    input  wire logic [DW-1:0] den,
    output speed_t             speed,
    output logic               sat
);

    logic [31:0]   mv_reg;
    logic [VW-1:0] mn_reg;
    logic          neg0_reg, zr0_reg;
    logic [DW-1:0] den0_reg;

    logic [61:0]   lo_reg, hi_reg;
    logic          neg1_reg, zr1_reg;
    logic [DW-1:0] den1_reg;

    logic [PW-1:0] p_reg;
    logic          neg2_reg, zr2_reg;
    logic [DW-1:0] den2_reg;

    logic [PW-1:0] rem_reg [0:QW];
    logic [QW-1:0] q_reg   [0:QW];
    logic          big_reg [0:QW];
    logic          neg_reg [0:QW];
    logic          zr_reg  [0:QW];
    logic [DW-1:0] dn_reg  [0:QW];

    speed_t speed_reg;
    logic   sat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mv_reg   <= v[31] ? 32'(-v) : 32'(v);
            mn_reg   <= num[VW-1] ? VW'(-num) : VW'(num);
            neg0_reg <= v[31] ^ num[VW-1];
            zr0_reg  <= (v == '0) || (num == '0);
            den0_reg <= den;

            lo_reg   <= mv_reg * mn_reg[29:0];
            hi_reg   <= mv_reg * mn_reg[59:30];
            neg1_reg <= neg0_reg;
            zr1_reg  <= zr0_reg;
            den1_reg <= den0_reg;

            p_reg    <= PW'(lo_reg) + (PW'(hi_reg) << 30);
            neg2_reg <= neg1_reg;
            zr2_reg  <= zr1_reg;
            den2_reg <= den1_reg;

            rem_reg[0] <= p_reg;
            q_reg[0]   <= '0;
            big_reg[0] <= p_reg >= (PW'(den2_reg) << 32);
            neg_reg[0] <= neg2_reg;
            zr_reg[0]  <= zr2_reg;
            dn_reg[0]  <= den2_reg;
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_bit
        localparam int B = QW - 1 - j;
        logic [PW-1:0] dsh;
        logic          ge;
        assign dsh = PW'(dn_reg[j]) << B;
        assign ge  = rem_reg[j] >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= ge ? (rem_reg[j] - dsh) : rem_reg[j];
                q_reg[j+1]   <= q_reg[j] | (ge ? (QW'(1) << B) : '0);
                big_reg[j+1] <= big_reg[j];
                neg_reg[j+1] <= neg_reg[j];
                zr_reg[j+1]  <= zr_reg[j];
                dn_reg[j+1]  <= dn_reg[j];
            end
        end
    end

    logic [QW-1:0] qf;
    logic          over;

    always_comb
    begin
        qf   = q_reg[QW];
        over = big_reg[QW] || (neg_reg[QW] ? (qf > 32'h8000_0000) : qf[31]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zr_reg[QW])
            begin
                speed_reg <= '0;
                sat_reg   <= 1'b0;
            end
            else if (over)
            begin
                speed_reg <= neg_reg[QW] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                sat_reg   <= 1'b1;
            end
            else
            begin
                speed_reg <= neg_reg[QW] ? -$signed(qf) : $signed(qf);
                sat_reg   <= 1'b0;
            end
        end
    end

    assign speed = speed_reg;
    assign sat   = sat_reg;

endmodule
`default_nettype wire

>>> src/ackermann_wheel_kinematics_top.sv
`default_nettype none
// Ackermann wheel kinematics. Each command beat (steer angle, speed) yields one result beat
// with both front steer angles and both rear wheel speeds. The pipeline takes one beat per
// cycle unless the result side stalls; the result beat is presented after its command
// beat passes the sine/cosine CORDIC stages, the product stages and the 32-stage restoring
// divider for the rear speeds. A stall on the result side holds the whole pipeline.
// Wheelbase and track are written through cfg_we, cfg_idx (0 wheelbase, 1 track) and
// cfg_data, only by the user while no command is in flight; the block does not enforce it.
module ackermann_wheel_kinematics_top import awk_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [CFG_W-1:0]     cfg_data,
    awk_cmd_if.sink                   cmd,
    awk_res_if.source                 res
);

    localparam int N   = CORDIC_STEPS;
    localparam int LAT = N + 40;
    localparam int DLY = 35 - N;

    logic [CFG_W-1:0] wheelbase_reg;
    logic [CFG_W-1:0] track_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheelbase_reg <= WHEELBASE_RST;
            track_reg     <= TRACK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_WHEELBASE: wheelbase_reg <= cfg_data;
                REG_TRACK:     track_reg     <= cfg_data;
                default:       ;
            endcase
        end
    end

    logic [24:0] l2;
    assign l2 = {wheelbase_reg, 1'b0};

    logic en;
    logic vld_reg [0:LAT-1];

    assign en        = !vld_reg[LAT-1] || res.ready;
    assign cmd.ready = en;
    assign res.valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= cmd.valid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    rot_t   rx_reg [0:N];
    rot_t   ry_reg [0:N];
    rot_t   rz_reg [0:N];
    speed_t v_reg  [0:N];

    logic signed [14:0] phic;
    always_comb
    begin
        if (cmd.steer_angle > PHI_MAX)
            phic = PHI_MAX;
        else if (cmd.steer_angle < PHI_MIN)
            phic = PHI_MIN;
        else
            phic = cmd.steer_angle;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg[0] <= CORDIC_GAIN;
            ry_reg[0] <= '0;
            rz_reg[0] <= {phic[14], phic, 17'd0};
            v_reg[0]  <= cmd.linear_speed;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        rot_t sx;
        rot_t sy;
        rot_t at;
        assign sx = rx_reg[i] >>> i;
        assign sy = ry_reg[i] >>> i;
        assign at = rot_t'(atan_q30(5'(i)));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[i+1] <= v_reg[i];
                if (!rz_reg[i][CW-1])
                begin
                    rx_reg[i+1] <= rx_reg[i] - sy;
                    ry_reg[i+1] <= ry_reg[i] + sx;
                    rz_reg[i+1] <= rz_reg[i] - at;
                end
                else
                begin
                    rx_reg[i+1] <= rx_reg[i] + sy;
                    ry_reg[i+1] <= ry_reg[i] - sx;
                    rz_reg[i+1] <= rz_reg[i] + at;
                end
            end
        end
    end

    logic [31:0] cp;
    assign cp = (rx_reg[N][CW-1] || rx_reg[N] == '0) ? 32'd1 : rx_reg[N][31:0];

    logic signed [58:0] l2s_reg;
    logic signed [57:0] ws_reg;
    logic signed [58:0] l2c_reg;
    logic [DW-1:0]      l2cp_reg;
    speed_t             vm_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l2s_reg  <= $signed({1'b0, l2}) * ry_reg[N];
            ws_reg   <= $signed({1'b0, track_reg}) * ry_reg[N];
            l2c_reg  <= $signed({1'b0, l2}) * rx_reg[N];
            l2cp_reg <= l2 * cp;
            vm_reg   <= v_reg[N];
        end
    end

    vec_t          dxl_reg, dxr_reg, dy_reg, dnl_reg, dnr_reg;
    logic [DW-1:0] dden_reg;
    speed_t        dv_reg;
    vec_t          l2c_x, ws_x, l2cp_x;

    assign l2c_x  = VW'(l2c_reg);
    assign ws_x   = VW'(ws_reg);
    assign l2cp_x = VW'(l2cp_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxl_reg  <= l2c_x - ws_x;
            dxr_reg  <= l2c_x + ws_x;
            dy_reg   <= VW'(l2s_reg);
            dnl_reg  <= l2cp_x - ws_x;
            dnr_reg  <= l2cp_x + ws_x;
            dden_reg <= l2cp_reg;
            dv_reg   <= vm_reg;
        end
    end

    angle_t fl, fr;

    awk_vec #(.STEPS(N)) u_vec_l (
        .clk   (clk),
        .en    (en),
        .x     (dxl_reg),
        .y     (dy_reg),
        .angle (fl)
    );

    awk_vec #(.STEPS(N)) u_vec_r (
        .clk   (clk),
        .en    (en),
        .x     (dxr_reg),
        .y     (dy_reg),
        .angle (fr)
    );

    angle_t fl_dly_reg [0:DLY-1];
    angle_t fr_dly_reg [0:DLY-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fl_dly_reg[0] <= fl;
            fr_dly_reg[0] <= fr;
            for (int k = 1; k < DLY; k++)
            begin
                fl_dly_reg[k] <= fl_dly_reg[k-1];
                fr_dly_reg[k] <= fr_dly_reg[k-1];
            end
        end
    end

    speed_t rl, rr;
    logic   sat_l, sat_r;

    awk_div u_div_l (
        .clk   (clk),
        .en    (en),
        .v     (dv_reg),
        .num   (dnl_reg),
        .den   (dden_reg),
        .speed (rl),
        .sat   (sat_l)
    );

    awk_div u_div_r (
        .clk   (clk),
        .en    (en),
        .v     (dv_reg),
        .num   (dnr_reg),
        .den   (dden_reg),
        .speed (rr),
        .sat   (sat_r)
    );

    assign res.front_left_angle  = fl_dly_reg[DLY-1];
    assign res.front_right_angle = fr_dly_reg[DLY-1];
    assign res.rear_left_speed   = rl;
    assign res.rear_right_speed  = rr;
    assign res.speed_saturated   = sat_l || sat_r || (wheelbase_reg == '0);

endmodule
`default_nettype wire
